/* hw/rtl/spl_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the spot light sampling pipeline.
package spl_pkg;

  localparam int COORD_W   = 32;
  localparam int MAG_W     = 32;
  localparam int SUM_W     = 66;
  localparam int LEN_W     = 33;
  localparam int QDIR_W    = 15;
  localparam int DIR_W     = 16;
  localparam int COS_W     = 20;
  localparam int RAD_W     = 16;
  localparam int DSQ_W     = 48;
  localparam int TMAX_W    = 31;
  localparam int CFG_W     = 48;
  localparam int CFG_IDX_W = 3;

  localparam int SQRT_STAGES = LEN_W;
  localparam int DDIV_STAGES = QDIR_W;
  localparam int RDIV_STAGES = RAD_W;

  localparam logic [LEN_W-1:0] TMIN_EPSILON = LEN_W'(7);

  localparam logic [CFG_W-1:0] AXIS_RESET  = 48'h0000_4000_0000;
  localparam logic [15:0]      OUTER_RESET = 16'sd11585;
  localparam logic [15:0]      INNER_RESET = 16'sd14189;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RADIANCE  = 3'd0,
    CFG_POS_X     = 3'd1,
    CFG_POS_Y     = 3'd2,
    CFG_POS_Z     = 3'd3,
    CFG_AXIS      = 3'd4,
    CFG_COS_OUTER = 3'd5,
    CFG_COS_INNER = 3'd6
  } spl_cfg_idx_t;

  // Output of the front end: magnitudes, signs and the exact squared length.
  typedef struct packed {
    logic [2:0][MAG_W-1:0] mag;
    logic [2:0]            neg;
    logic [SUM_W-1:0]      sum_sq;
  } spl_front_t;

  // Data that rides alongside the direction divider.
  typedef struct packed {
    logic [2:0]       neg;
    logic [LEN_W-1:0] len;
    logic [SUM_W-1:0] sum_sq;
  } spl_dir_side_t;

  // Data that rides alongside the ramp divider.
  typedef struct packed {
    logic                  lit;
    logic                  full;
    logic [2:0][RAD_W-1:0] rad;
    logic [DSQ_W-1:0]      dsq;
    logic [2:0][DIR_W-1:0] dir;
    logic [TMAX_W-1:0]     tmax;
  } spl_ramp_side_t;

endpackage

/* hw/rtl/spot_light_sample.sv */
`timescale 1ns / 1ps
// Top level of the spot light sampling pipeline.
//
// Channel  Direction  Handshake                  Content
// s_axis   in         tvalid/tready              one shading point
// m_axis   out        tvalid/tready              one illumination result
// cfg      in         cfg_we, no back-pressure   light and cone registers
//
// One point enters per cycle while the pipeline is not held; the pipeline depth
// is set by the 33-stage square root and the two restoring dividers.
// Reset (rst, synchronous) empties the pipeline and loads the register
// defaults. When a finished result is not taken the whole pipeline holds,
// and s_axis_tready falls with it; nothing is dropped or repeated.
module spot_light_sample (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // point_x [31:0], point_y [63:32], point_z [95:64]
  input  logic [95:0]                       s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // rad_r [15:0], rad_g [31:16], rad_b [47:32], dist_sq_pdf [95:48],
  // shadow_dir_x [111:96], shadow_dir_y [127:112], shadow_dir_z [143:128],
  // shadow_tmax [174:144], zero [175]
  output logic [175:0]                      m_axis_tdata,
  // lit [0]
  output logic                              m_axis_tuser,
  input  logic                              cfg_we,
  input  logic [spl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [spl_pkg::CFG_W-1:0]         cfg_wdata
);

  logic                                   en;

  logic [47:0]                            rad_rgb;
  logic [2:0][31:0]                       pos;
  logic [47:0]                            axis;
  logic [15:0]                            cos_outer;
  logic [15:0]                            cos_inner;

  logic [2:0][31:0]                       point;
  logic                                   f_valid;
  spl_pkg::spl_front_t                    f_data;
  logic                                   r_valid;
  logic [spl_pkg::LEN_W-1:0]              r_len;
  spl_pkg::spl_front_t                    r_data;
  spl_pkg::spl_dir_side_t                 dd_side_in;
  logic                                   dd_valid;
  logic [2:0][spl_pkg::QDIR_W-1:0]        dd_quot;
  spl_pkg::spl_dir_side_t                 dd_side;

  logic                                   v1, v2, v3, v4;
  logic [2:0][spl_pkg::DIR_W-1:0]         dir1, dir2, dir3, dir4;
  logic [spl_pkg::DSQ_W-1:0]              dsq1, dsq2, dsq3, dsq4;
  logic [spl_pkg::TMAX_W-1:0]             tmax1, tmax2, tmax3, tmax4;
  logic signed [31:0]                     prod2 [3];
  logic signed [spl_pkg::COS_W-1:0]       cos3;
  logic                                   lit4, full4;
  logic [spl_pkg::RAD_W-1:0]              num4, den4;

  logic [spl_pkg::LEN_W-1:0]              tsub;
  logic [2:0][spl_pkg::QDIR_W:0]          qneg;
  logic signed [33:0]                     psum;
  logic signed [33:0]                     dot;
  logic signed [spl_pkg::COS_W-1:0]       cout_ext, cin_ext;
  logic [spl_pkg::COS_W-1:0]              num_full;
  logic [16:0]                            den_full;
  spl_pkg::spl_ramp_side_t                rp_side_in;

  logic                                   rp_valid;
  logic [2:0][spl_pkg::RAD_W-1:0]         rp_quot;
  spl_pkg::spl_ramp_side_t                rp_side;

  logic [2:0][spl_pkg::RAD_W-1:0]         rad_sel;

  // The pipeline advances whenever the output register can move.
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      rad_rgb   <= '0;
      pos       <= '0;
      axis      <= spl_pkg::AXIS_RESET;
      cos_outer <= spl_pkg::OUTER_RESET;
      cos_inner <= spl_pkg::INNER_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        spl_pkg::CFG_RADIANCE:  rad_rgb   <= cfg_wdata;
        spl_pkg::CFG_POS_X:     pos[0]    <= cfg_wdata[31:0];
        spl_pkg::CFG_POS_Y:     pos[1]    <= cfg_wdata[31:0];
        spl_pkg::CFG_POS_Z:     pos[2]    <= cfg_wdata[31:0];
        spl_pkg::CFG_AXIS:      axis      <= cfg_wdata;
        spl_pkg::CFG_COS_OUTER: cos_outer <= cfg_wdata[15:0];
        spl_pkg::CFG_COS_INNER: cos_inner <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  assign point[0] = s_axis_tdata[31:0];
  assign point[1] = s_axis_tdata[63:32];
  assign point[2] = s_axis_tdata[95:64];

  spl_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_axis_tvalid),
    .point     (point),
    .pos       (pos),
    .out_valid (f_valid),
    .out_data  (f_data)
  );

  spl_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f_valid),
    .in_data   (f_data),
    .out_valid (r_valid),
    .len       (r_len),
    .out_data  (r_data)
  );

  assign dd_side_in.neg    = r_data.neg;
  assign dd_side_in.len    = r_len;
  assign dd_side_in.sum_sq = r_data.sum_sq;

  spl_dir_div u_dir_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (r_valid),
    .mag       (r_data.mag),
    .in_side   (dd_side_in),
    .out_valid (dd_valid),
    .quot      (dd_quot),
    .out_side  (dd_side)
  );

  // Signed direction, distance terms and the axis products.
  assign tsub = dd_side.len - spl_pkg::TMIN_EPSILON;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qneg[i] = (spl_pkg::QDIR_W + 1)'(0) - {1'b0, dd_quot[i]};
    end
  end

  // Sum of the products, negated; the floor shift keeps the upper bits.
  assign psum = 34'(prod2[0]) + 34'(prod2[1]) + 34'(prod2[2]);
  assign dot  = 34'sd0 - psum;

  // Cone test against the outer and inner cosines at full width.
  assign cout_ext = {{(spl_pkg::COS_W-16){cos_outer[15]}}, cos_outer};
  assign cin_ext  = {{(spl_pkg::COS_W-16){cos_inner[15]}}, cos_inner};
  assign num_full = cos3 - cout_ext;
  assign den_full = {cos_inner[15], cos_inner} - {cos_outer[15], cos_outer};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= dd_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (dd_side.len == '0) begin
          dir1[i] <= '0;
        end else if (dd_side.neg[i]) begin
          dir1[i] <= qneg[i];
        end else begin
          dir1[i] <= {1'b0, dd_quot[i]};
        end
        prod2[i] <= $signed(dir1[i]) * $signed(axis[16*i +: 16]);
      end
      dsq1 <= (dd_side.sum_sq[65:64] != 2'b00) ? '1 : dd_side.sum_sq[63:16];
      if (dd_side.len <= spl_pkg::TMIN_EPSILON) begin
        tmax1 <= '0;
      end else if (tsub[32:31] != 2'b00) begin
        tmax1 <= '1;
      end else begin
        tmax1 <= tsub[30:0];
      end
      dir2  <= dir1;
      dsq2  <= dsq1;
      tmax2 <= tmax1;
      cos3  <= dot[33:14];
      dir3  <= dir2;
      dsq3  <= dsq2;
      tmax3 <= tmax2;
      lit4  <= cos3 > cout_ext;
      full4 <= cos3 > cin_ext;
      num4  <= num_full[spl_pkg::RAD_W-1:0];
      den4  <= den_full[spl_pkg::RAD_W-1:0];
      dir4  <= dir3;
      dsq4  <= dsq3;
      tmax4 <= tmax3;
    end
  end

  assign rp_side_in.lit  = lit4;
  assign rp_side_in.full = full4;
  assign rp_side_in.rad  = rad_rgb;
  assign rp_side_in.dsq  = dsq4;
  assign rp_side_in.dir  = dir4;
  assign rp_side_in.tmax = tmax4;

  spl_ramp_div u_ramp_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v4),
    .num       (num4),
    .den       (den4),
    .in_side   (rp_side_in),
    .out_valid (rp_valid),
    .quot      (rp_quot),
    .out_side  (rp_side)
  );

  // Full radiance inside the inner cone, the ramp between the cones.
  assign rad_sel = rp_side.full ? rp_side.rad : rp_quot;

  // Output register; an unlit point gives an all-zero result.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= rp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tuser <= rp_side.lit;
      if (rp_side.lit) begin
        m_axis_tdata <= {1'b0, rp_side.tmax, rp_side.dir[2], rp_side.dir[1],
                         rp_side.dir[0], rp_side.dsq, rad_sel[2], rad_sel[1],
                         rad_sel[0]};
      end else begin
        m_axis_tdata <= '0;
      end
    end
  end

endmodule

/* hw/rtl/spl_front.sv */
`timescale 1ns / 1ps
// Front end: vector to the light, split squares and the sum of squares.
module spl_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  logic [2:0][spl_pkg::COORD_W-1:0]     point,
  input  logic [2:0][spl_pkg::COORD_W-1:0]     pos,
  output logic                                 out_valid,
  output spl_pkg::spl_front_t                  out_data
);

  logic [32:0]                      diff [3];
  logic [32:0]                      ndiff [3];
  logic [2:0][spl_pkg::MAG_W-1:0]   mag_c;
  logic [2:0]                       neg_c;

  logic                             v1, v2, v3, v4;
  logic [2:0][spl_pkg::MAG_W-1:0]   mag1, mag2, mag3, mag4;
  logic [2:0]                       neg1, neg2, neg3, neg4;
  logic [2:0][31:0]                 hh, hl, ll;
  logic [2:0][63:0]                 sq;
  logic [spl_pkg::SUM_W-1:0]        sum_sq;

  // Difference and magnitude per axis.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i]  = {pos[i][31], pos[i]} - {point[i][31], point[i]};
      ndiff[i] = 33'd0 - diff[i];
      neg_c[i] = diff[i][32];
      mag_c[i] = neg_c[i] ? ndiff[i][31:0] : diff[i][31:0];
    end
  end

  // Valid bits of the four stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // Stage one holds the magnitudes, stage two the half-word products,
  // stage three the squares and stage four their sum.
  always_ff @(posedge clk) begin
    if (en) begin
      mag1 <= mag_c;
      neg1 <= neg_c;
      for (int i = 0; i < 3; i++) begin
        hh[i] <= mag1[i][31:16] * mag1[i][31:16];
        hl[i] <= mag1[i][31:16] * mag1[i][15:0];
        ll[i] <= mag1[i][15:0] * mag1[i][15:0];
        sq[i] <= {hh[i], ll[i]} + {15'd0, hl[i], 17'd0};
      end
      mag2   <= mag1;
      neg2   <= neg1;
      mag3   <= mag2;
      neg3   <= neg2;
      sum_sq <= spl_pkg::SUM_W'(sq[0]) + spl_pkg::SUM_W'(sq[1])
              + spl_pkg::SUM_W'(sq[2]);
      mag4   <= mag3;
      neg4   <= neg3;
    end
  end

  assign out_valid       = v4;
  assign out_data.mag    = mag4;
  assign out_data.neg    = neg4;
  assign out_data.sum_sq = sum_sq;

endmodule

/* hw/rtl/spl_sqrt.sv */
`timescale 1ns / 1ps
// Pipelined floor square root of the squared length, one root bit a stage.
module spl_sqrt (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            in_valid,
  input  spl_pkg::spl_front_t             in_data,
  output logic                            out_valid,
  output logic [spl_pkg::LEN_W-1:0]       len,
  output spl_pkg::spl_front_t             out_data
);

  localparam int N = spl_pkg::SQRT_STAGES;

  logic                       vld  [N];
  logic [33:0]                rem  [N];
  logic [spl_pkg::LEN_W-1:0]  root [N];
  spl_pkg::spl_front_t        side [N];

  for (genvar s = 0; s < N; s++) begin : g_stage
    localparam int I = N - 1 - s;
    logic                       v_in;
    logic [33:0]                rem_in;
    logic [spl_pkg::LEN_W-1:0]  root_in;
    spl_pkg::spl_front_t        side_in;
    logic [35:0]                cur;
    logic [35:0]                trial;
    logic [35:0]                diff;
    logic                       fit;

    if (s == 0) begin : g_first
      assign v_in    = in_valid;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = in_data;
    end else begin : g_next
      assign v_in    = vld[s-1];
      assign rem_in  = rem[s-1];
      assign root_in = root[s-1];
      assign side_in = side[s-1];
    end

    // Bring down the next bit pair and try the next root bit.
    assign cur   = {rem_in, side_in.sum_sq[2*I+1 -: 2]};
    assign trial = {1'b0, root_in, 2'b01};
    assign diff  = cur - trial;
    assign fit   = (cur >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s]  <= fit ? diff[33:0] : cur[33:0];
        root[s] <= {root_in[spl_pkg::LEN_W-2:0], fit};
        side[s] <= side_in;
      end
    end
  end

  assign out_valid = vld[N-1];
  assign len       = root[N-1];
  assign out_data  = side[N-1];

endmodule

/* hw/rtl/spl_dir_div.sv */
`timescale 1ns / 1ps
// Three-lane restoring divider for the unit direction, one quotient bit a stage.
module spl_dir_div (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   en,
  input  logic                                   in_valid,
  input  logic [2:0][spl_pkg::MAG_W-1:0]         mag,
  input  spl_pkg::spl_dir_side_t                 in_side,
  output logic                                   out_valid,
  output logic [2:0][spl_pkg::QDIR_W-1:0]        quot,
  output spl_pkg::spl_dir_side_t                 out_side
);

  localparam int N = spl_pkg::DDIV_STAGES;

  logic                                      vld  [N];
  logic [2:0][spl_pkg::LEN_W-1:0]            rem  [N];
  logic [2:0][spl_pkg::QDIR_W-1:0]           q    [N];
  spl_pkg::spl_dir_side_t                    side [N];

  for (genvar s = 0; s < N; s++) begin : g_stage
    logic                                v_in;
    logic [2:0][spl_pkg::LEN_W:0]        cur;
    logic [2:0][spl_pkg::QDIR_W-1:0]     q_in;
    spl_pkg::spl_dir_side_t              side_in;
    logic [2:0][spl_pkg::LEN_W:0]        diff;
    logic [2:0]                          fit;

    // The first stage sees the numerator magnitude, zero-extended and unshifted.
    if (s == 0) begin : g_first
      assign v_in    = in_valid;
      assign q_in    = '0;
      assign side_in = in_side;
      for (genvar l = 0; l < 3; l++) begin : g_lane
        assign cur[l] = {2'b00, mag[l]};
      end
    end else begin : g_next
      assign v_in    = vld[s-1];
      assign q_in    = q[s-1];
      assign side_in = side[s-1];
      for (genvar l = 0; l < 3; l++) begin : g_lane
        assign cur[l] = {rem[s-1][l], 1'b0};
      end
    end

    for (genvar l = 0; l < 3; l++) begin : g_cmp
      assign diff[l] = cur[l] - {1'b0, side_in.len};
      assign fit[l]  = (cur[l] >= {1'b0, side_in.len});
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < 3; l++) begin
          rem[s][l] <= fit[l] ? diff[l][spl_pkg::LEN_W-1:0] : cur[l][spl_pkg::LEN_W-1:0];
          q[s][l]   <= {q_in[l][spl_pkg::QDIR_W-2:0], fit[l]};
        end
        side[s] <= side_in;
      end
    end
  end

  assign out_valid = vld[N-1];
  assign quot      = q[N-1];
  assign out_side  = side[N-1];

endmodule

/* hw/rtl/spl_ramp_div.sv */
`timescale 1ns / 1ps
// Radiance ramp: product with the cone margin, then a three-lane divider.
module spl_ramp_div (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  logic [spl_pkg::RAD_W-1:0]            num,
  input  logic [spl_pkg::RAD_W-1:0]            den,
  input  spl_pkg::spl_ramp_side_t              in_side,
  output logic                                 out_valid,
  output logic [2:0][spl_pkg::RAD_W-1:0]       quot,
  output spl_pkg::spl_ramp_side_t              out_side
);

  localparam int N = spl_pkg::RDIV_STAGES;
  localparam int W = spl_pkg::RAD_W;

  logic                        pv;
  logic [2:0][2*W-1:0]         prod;
  logic [W-1:0]                pden;
  spl_pkg::spl_ramp_side_t     pside;

  logic                        vld  [N];
  logic [2:0][W-1:0]           rem  [N];
  logic [2:0][W-1:0]           lo   [N];
  logic [2:0][W-1:0]           q    [N];
  logic [W-1:0]                dreg [N];
  spl_pkg::spl_ramp_side_t     side [N];

  // Product stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
    end else if (en) begin
      pv <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        prod[l] <= in_side.rad[l] * num;
      end
      pden  <= den;
      pside <= in_side;
    end
  end

  // Division stages, most significant quotient bit first.
  for (genvar s = 0; s < N; s++) begin : g_stage
    logic                    v_in;
    logic [2:0][W-1:0]       rem_in;
    logic [2:0][W-1:0]       lo_in;
    logic [2:0][W-1:0]       q_in;
    logic [W-1:0]            d_in;
    spl_pkg::spl_ramp_side_t side_in;
    logic [2:0][W:0]         cur;
    logic [2:0][W:0]         diff;
    logic [2:0]              fit;

    if (s == 0) begin : g_first
      assign v_in    = pv;
      assign d_in    = pden;
      assign side_in = pside;
      assign q_in    = '0;
      for (genvar l = 0; l < 3; l++) begin : g_lane
        assign rem_in[l] = prod[l][2*W-1:W];
        assign lo_in[l]  = prod[l][W-1:0];
      end
    end else begin : g_next
      assign v_in    = vld[s-1];
      assign d_in    = dreg[s-1];
      assign side_in = side[s-1];
      assign q_in    = q[s-1];
      assign rem_in  = rem[s-1];
      assign lo_in   = lo[s-1];
    end

    for (genvar l = 0; l < 3; l++) begin : g_cmp
      assign cur[l]  = {rem_in[l], lo_in[l][W-1]};
      assign diff[l] = cur[l] - {1'b0, d_in};
      assign fit[l]  = (cur[l] >= {1'b0, d_in});
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < 3; l++) begin
          rem[s][l] <= fit[l] ? diff[l][W-1:0] : cur[l][W-1:0];
          lo[s][l]  <= {lo_in[l][W-2:0], 1'b0};
          q[s][l]   <= {q_in[l][W-2:0], fit[l]};
        end
        dreg[s] <= d_in;
        side[s] <= side_in;
      end
    end
  end

  assign out_valid = vld[N-1];
  assign quot      = q[N-1];
  assign out_side  = side[N-1];

endmodule
